// File: hdl/teat_pkg.sv
// shared types, codes and calendar helpers for the timestamped entry aging table
// no dependencies; imported by the top level, the age unit and the checker
`default_nettype none

package teat_pkg;

    localparam int SHORT_DEPTH_DEF = 32;
    localparam int LONG_DEPTH_DEF  = 64;
    localparam int PERM_DEPTH_DEF  = 16;

    localparam int FILL_W  = 7;
    localparam int DAY_W   = 24;
    localparam int HM_W    = 11;
    localparam int AGE_W   = 36;
    localparam int TMO_W   = 24;

    localparam int YEAR_DAYS   = 365;
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int CENTURY     = 100;

    localparam logic [TMO_W-1:0] SHORT_TMO_RST = 24'd480;
    localparam logic [TMO_W-1:0] LONG_TMO_RST  = 24'd43200;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_EXPIRE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CLS_SHORT   = 2'd0,
        CLS_LONG    = 2'd1,
        CLS_PERM    = 2'd2,
        CLS_INVALID = 2'd3
    } mem_class_t;

    typedef enum logic {
        CFG_SHORT_TMO = 1'b0,
        CFG_LONG_TMO  = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_NOW,
        ST_NOW_CAP,
        ST_SCAN_CHK,
        ST_SCAN_DAY,
        ST_SCAN_AGE,
        ST_SCAN_DEC,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } stamp_t;

    typedef struct packed {
        logic [31:0] content;
        logic [31:0] related;
        stamp_t      stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // days in the year before the first of month m, non-leap
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd0, 4'd1: r = 9'd0;
            4'd2:       r = 9'd31;
            4'd3:       r = 9'd59;
            4'd4:       r = 9'd90;
            4'd5:       r = 9'd120;
            4'd6:       r = 9'd151;
            4'd7:       r = 9'd181;
            4'd8:       r = 9'd212;
            4'd9:       r = 9'd243;
            4'd10:      r = 9'd273;
            4'd11:      r = 9'd304;
            4'd12:      r = 9'd334;
            default:    r = 9'd365;
        endcase
        return r;
    endfunction

    // days since 1 january of year 1; reciprocal multiply stands in for /100
    function automatic logic signed [DAY_W-1:0] day_number(input stamp_t s);
        logic [13:0] p;
        logic [11:0] p4;
        logic [27:0] prod_p;
        logic [27:0] prod_p4;
        logic [27:0] prod_y;
        logic [7:0]  q100;
        logic [5:0]  q400;
        logic [7:0]  qy;
        logic [15:0] qy_cent;
        logic        leap;
        logic [24:0] total;
        p       = (s.year == 14'd0) ? 14'd0 : s.year - 14'd1;
        p4      = p[13:2];
        prod_p  = 28'(p) * 28'(RECIP_100);
        prod_p4 = 28'(p4) * 28'(RECIP_100);
        prod_y  = 28'(s.year) * 28'(RECIP_100);
        q100    = 8'(prod_p >> RECIP_SHIFT);
        q400    = 6'(prod_p4 >> RECIP_SHIFT);
        qy      = 8'(prod_y >> RECIP_SHIFT);
        qy_cent = 16'(qy) * 16'(CENTURY);
        leap    = (s.year[1:0] == 2'd0)
               && ((qy_cent != 16'(s.year)) || (qy[1:0] == 2'd0));
        total   = 25'(p) * 25'(YEAR_DAYS) + 25'(p4) - 25'(q100) + 25'(q400)
                + 25'(days_before_month(s.month))
                + 25'((leap && (s.month > 4'd2)) ? 1 : 0)
                + 25'(s.day);
        return DAY_W'($signed(total) - 25'sd1);
    endfunction

endpackage

`default_nettype wire

// File: hdl/timestamped_entry_aging_table_top.sv
// path from acceptance to result word: add and clear go through the execute and finish states;
// read adds a wait state for the ram when the index is valid; expire scans every stored short/long entry,
// one entry read, aged and written back at a time
// one item in flight; the next word is taken in the cycle after the result is loaded,
// even while that result still waits
// rst_n asynchronous active low: tables empty, timeouts 480 and 43200 minutes
// top level: sequencer, three entry rams and the shared age unit
// depends on teat_pkg, teat_ram, teat_age_unit
`default_nettype none

module timestamped_entry_aging_table_top #(
    parameter int SHORT_DEPTH = teat_pkg::SHORT_DEPTH_DEF,
    parameter int LONG_DEPTH  = teat_pkg::LONG_DEPTH_DEF,
    parameter int PERM_DEPTH  = teat_pkg::PERM_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [23:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [1:0]  mem_class,
    input  wire logic [13:0] stamp_year,
    input  wire logic [3:0]  stamp_month,
    input  wire logic [4:0]  stamp_day,
    input  wire logic [4:0]  stamp_hour,
    input  wire logic [5:0]  stamp_minute,
    input  wire logic [31:0] content_handle,
    input  wire logic [31:0] related_handle,
    input  wire logic [5:0]  entry_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             ok,
    output logic [5:0]       short_level,
    output logic [6:0]       long_level,
    output logic [4:0]       perm_level,
    output logic [31:0]      read_content,
    output logic [31:0]      read_related,
    output logic [13:0]      read_year,
    output logic [3:0]       read_month,
    output logic [4:0]       read_day,
    output logic [4:0]       read_hour,
    output logic [5:0]       read_minute
);
    import teat_pkg::*;

    localparam int S_AW = (SHORT_DEPTH > 1) ? $clog2(SHORT_DEPTH) : 1;
    localparam int L_AW = (LONG_DEPTH > 1) ? $clog2(LONG_DEPTH) : 1;
    localparam int P_AW = (PERM_DEPTH > 1) ? $clog2(PERM_DEPTH) : 1;

    state_t state_reg, state_next;

    opcode_t          op_reg;
    mem_class_t       cls_reg;
    entry_t           item_reg;
    logic [5:0]       index_reg;

    logic [FILL_W-1:0] s_fill_reg, s_fill_next;
    logic [FILL_W-1:0] l_fill_reg, l_fill_next;
    logic [FILL_W-1:0] p_fill_reg, p_fill_next;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic [FILL_W-1:0] kept_reg, kept_next;
    logic              tsel_reg, tsel_next;
    logic              work_ok_reg, work_ok_next;
    logic              hit_reg, hit_next;
    entry_t            hit_entry_reg, hit_entry_next;

    logic signed [DAY_W-1:0] now_days_reg;
    logic [HM_W-1:0]         now_hm_reg;
    logic [TMO_W-1:0]        s_tmo_reg, l_tmo_reg;

    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg;
    logic [FILL_W-1:0] out_s_reg, out_l_reg, out_p_reg;
    entry_t            out_entry_reg;

    logic              s_we, l_we, p_we;
    logic [FILL_W-1:0] s_waddr, l_waddr;
    entry_t            s_wdata, l_wdata;
    logic [FILL_W-1:0] raddr;
    entry_t            s_rdata, l_rdata, p_rdata;

    stamp_t                  unit_stamp;
    logic signed [DAY_W-1:0] unit_days;
    logic [HM_W-1:0]         unit_hm;
    logic                    unit_expired;

    logic              accept;
    logic              out_free;
    logic [FILL_W-1:0] cur_fill;
    entry_t            cur_rdata;
    logic              add_ok;
    logic              read_ok;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign cur_fill  = tsel_reg ? l_fill_reg : s_fill_reg;
    assign cur_rdata = tsel_reg ? l_rdata : s_rdata;

    always_comb
    begin
        unique case (cls_reg)
            CLS_SHORT:
            begin
                add_ok  = s_fill_reg < FILL_W'(SHORT_DEPTH);
                read_ok = FILL_W'(index_reg) < s_fill_reg;
            end
            CLS_LONG:
            begin
                add_ok  = l_fill_reg < FILL_W'(LONG_DEPTH);
                read_ok = FILL_W'(index_reg) < l_fill_reg;
            end
            CLS_PERM:
            begin
                add_ok  = p_fill_reg < FILL_W'(PERM_DEPTH);
                read_ok = FILL_W'(index_reg) < p_fill_reg;
            end
            default:
            begin
                add_ok  = 1'b0;
                read_ok = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_EXPIRE: state_next = ST_NOW;
                    OP_READ:   state_next = read_ok ? ST_READ_WAIT : ST_FINISH;
                    default:   state_next = ST_FINISH;
                endcase
            end
            ST_READ_WAIT: state_next = ST_FINISH;
            ST_NOW:       state_next = ST_NOW_CAP;
            ST_NOW_CAP:   state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
            begin
                if (idx_reg < cur_fill)
                begin
                    state_next = ST_SCAN_DAY;
                end
                else if (tsel_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN_DAY:  state_next = ST_SCAN_AGE;
            ST_SCAN_AGE:  state_next = ST_SCAN_DEC;
            ST_SCAN_DEC:  state_next = ST_SCAN_CHK;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        s_fill_next    = s_fill_reg;
        l_fill_next    = l_fill_reg;
        p_fill_next    = p_fill_reg;
        idx_next       = idx_reg;
        kept_next      = kept_reg;
        tsel_next      = tsel_reg;
        work_ok_next   = work_ok_reg;
        hit_next       = hit_reg;
        hit_entry_next = hit_entry_reg;
        out_valid_next = out_valid_reg && out_stall;
        s_we           = 1'b0;
        l_we           = 1'b0;
        p_we           = 1'b0;
        s_waddr        = kept_reg;
        l_waddr        = kept_reg;
        s_wdata        = s_rdata;
        l_wdata        = l_rdata;
        raddr          = idx_reg;
        unit_stamp     = cur_rdata.stamp;
        unique case (state_reg)
            ST_EXEC:
            begin
                work_ok_next = 1'b0;
                hit_next     = 1'b0;
                raddr        = FILL_W'(index_reg);
                unique case (op_reg)
                    OP_ADD:
                    begin
                        work_ok_next = add_ok;
                        s_waddr      = s_fill_reg;
                        l_waddr      = l_fill_reg;
                        s_wdata      = item_reg;
                        l_wdata      = item_reg;
                        if (add_ok)
                        begin
                            unique case (cls_reg)
                                CLS_SHORT:
                                begin
                                    s_we        = 1'b1;
                                    s_fill_next = s_fill_reg + 1'b1;
                                end
                                CLS_LONG:
                                begin
                                    l_we        = 1'b1;
                                    l_fill_next = l_fill_reg + 1'b1;
                                end
                                default:
                                begin
                                    p_we        = 1'b1;
                                    p_fill_next = p_fill_reg + 1'b1;
                                end
                            endcase
                        end
                    end
                    OP_EXPIRE:
                    begin
                        work_ok_next = 1'b1;
                    end
                    OP_READ:
                    begin
                        work_ok_next = read_ok;
                        hit_next     = read_ok;
                    end
                    default:
                    begin
                        work_ok_next = 1'b1;
                        s_fill_next  = '0;
                        l_fill_next  = '0;
                        p_fill_next  = '0;
                    end
                endcase
            end
            ST_READ_WAIT:
            begin
                unique case (cls_reg)
                    CLS_SHORT: hit_entry_next = s_rdata;
                    CLS_LONG:  hit_entry_next = l_rdata;
                    default:   hit_entry_next = p_rdata;
                endcase
            end
            ST_NOW:
            begin
                unit_stamp = item_reg.stamp;
            end
            ST_NOW_CAP:
            begin
                tsel_next = 1'b0;
                idx_next  = '0;
                kept_next = '0;
            end
            ST_SCAN_CHK:
            begin
                if (!(idx_reg < cur_fill))
                begin
                    if (tsel_reg)
                    begin
                        l_fill_next = kept_reg;
                    end
                    else
                    begin
                        s_fill_next = kept_reg;
                    end
                    tsel_next = 1'b1;
                    idx_next  = '0;
                    kept_next = '0;
                end
            end
            ST_SCAN_DEC:
            begin
                idx_next = idx_reg + 1'b1;
                if (!unit_expired)
                begin
                    // compaction: survivor moves down to the next kept slot
                    s_we      = !tsel_reg;
                    l_we      = tsel_reg;
                    kept_next = kept_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s_fill_reg    <= '0;
            l_fill_reg    <= '0;
            p_fill_reg    <= '0;
            out_valid_reg <= 1'b0;
            s_tmo_reg     <= SHORT_TMO_RST;
            l_tmo_reg     <= LONG_TMO_RST;
        end
        else
        begin
            state_reg     <= state_next;
            s_fill_reg    <= s_fill_next;
            l_fill_reg    <= l_fill_next;
            p_fill_reg    <= p_fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_SHORT_TMO: s_tmo_reg <= cfg_wdata;
                    CFG_LONG_TMO:  l_tmo_reg <= cfg_wdata;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        kept_reg      <= kept_next;
        tsel_reg      <= tsel_next;
        work_ok_reg   <= work_ok_next;
        hit_reg       <= hit_next;
        hit_entry_reg <= hit_entry_next;
        if (accept)
        begin
            op_reg                <= opcode_t'(opcode);
            cls_reg               <= mem_class_t'(mem_class);
            item_reg.content      <= content_handle;
            item_reg.related      <= related_handle;
            item_reg.stamp.year   <= stamp_year;
            item_reg.stamp.month  <= stamp_month;
            item_reg.stamp.day    <= stamp_day;
            item_reg.stamp.hour   <= stamp_hour;
            item_reg.stamp.minute <= stamp_minute;
            index_reg             <= entry_index;
        end
        if (state_reg == ST_NOW_CAP)
        begin
            now_days_reg <= unit_days;
            now_hm_reg   <= unit_hm;
        end
        if (state_reg == ST_FINISH && out_free)
        begin
            out_ok_reg    <= work_ok_reg;
            out_s_reg     <= s_fill_reg;
            out_l_reg     <= l_fill_reg;
            out_p_reg     <= p_fill_reg;
            out_entry_reg <= hit_reg ? hit_entry_reg : '0;
        end
    end

    teat_ram #(.WIDTH(ENTRY_W), .DEPTH(SHORT_DEPTH)) u_short_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr[S_AW-1:0]),
        .wdata (s_wdata),
        .raddr (raddr[S_AW-1:0]),
        .rdata (s_rdata)
    );

    teat_ram #(.WIDTH(ENTRY_W), .DEPTH(LONG_DEPTH)) u_long_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr[L_AW-1:0]),
        .wdata (l_wdata),
        .raddr (raddr[L_AW-1:0]),
        .rdata (l_rdata)
    );

    teat_ram #(.WIDTH(ENTRY_W), .DEPTH(PERM_DEPTH)) u_perm_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_fill_reg[P_AW-1:0]),
        .wdata (item_reg),
        .raddr (raddr[P_AW-1:0]),
        .rdata (p_rdata)
    );

    teat_age_unit u_age (
        .clk         (clk),
        .stamp       (unit_stamp),
        .now_days    (now_days_reg),
        .now_hm      (now_hm_reg),
        .limit       (tsel_reg ? l_tmo_reg : s_tmo_reg),
        .days_reg    (unit_days),
        .hm_reg      (unit_hm),
        .expired_reg (unit_expired)
    );

    assign out_valid    = out_valid_reg;
    assign ok           = out_ok_reg;
    assign short_level  = out_s_reg[5:0];
    assign long_level   = out_l_reg;
    assign perm_level   = out_p_reg[4:0];
    assign read_content = out_entry_reg.content;
    assign read_related = out_entry_reg.related;
    assign read_year    = out_entry_reg.stamp.year;
    assign read_month   = out_entry_reg.stamp.month;
    assign read_day     = out_entry_reg.stamp.day;
    assign read_hour    = out_entry_reg.stamp.hour;
    assign read_minute  = out_entry_reg.stamp.minute;

endmodule

`default_nettype wire

// File: hdl/teat_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module teat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/teat_age_unit.sv
// shared calendar unit: day number then age in minutes against a timeout
// depends on teat_pkg
`default_nettype none

module teat_age_unit (
    input  wire logic                               clk,
    input  wire teat_pkg::stamp_t                   stamp,
    input  wire logic signed [teat_pkg::DAY_W-1:0]  now_days,
    input  wire logic [teat_pkg::HM_W-1:0]          now_hm,
    input  wire logic [teat_pkg::TMO_W-1:0]         limit,
    output logic signed [teat_pkg::DAY_W-1:0]       days_reg,
    output logic [teat_pkg::HM_W-1:0]               hm_reg,
    output logic                                    expired_reg
);
    import teat_pkg::*;

    logic signed [DAY_W:0]   diff;
    logic signed [AGE_W-1:0] age;
    logic signed [AGE_W-1:0] dd;
    logic                    expired_next;

    // stage one: calendar day number and minute of day
    always_ff @(posedge clk)
    begin
        days_reg <= day_number(stamp);
        hm_reg   <= HM_W'(stamp.hour) * HM_W'(60) + HM_W'(stamp.minute);
    end

    // stage two: 1440 = 1024 + 256 + 128 + 32
    always_comb
    begin
        diff = (DAY_W+1)'(now_days) - (DAY_W+1)'(days_reg);
        dd   = AGE_W'(diff);
        age  = (dd <<< 10) + (dd <<< 8) + (dd <<< 7) + (dd <<< 5)
             + $signed({{(AGE_W-HM_W){1'b0}}, now_hm})
             - $signed({{(AGE_W-HM_W){1'b0}}, hm_reg});
        expired_next = age > $signed({{(AGE_W-TMO_W){1'b0}}, limit});
    end

    always_ff @(posedge clk)
    begin
        expired_reg <= expired_next;
    end

endmodule

`default_nettype wire

// File: hdl/teat_checker.sv
// port-level checks for the aging table, bound to the top level
// depends on teat_pkg and timestamped_entry_aging_table_top
`default_nettype none

module teat_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        ok,
    input wire logic [5:0]  short_level,
    input wire logic [6:0]  long_level,
    input wire logic [4:0]  perm_level,
    input wire logic [31:0] read_content,
    input wire logic [13:0] read_year
);
    import teat_pkg::*;

    // one word in flight: the input side closes right after a word is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a word is in flight");

    // a failed step never shows read data
    a_zero_when_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> read_content == 32'd0 && read_year == 14'd0)
        else $error("read fields nonzero on a refused step");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(short_level) <= SHORT_DEPTH_DEF
                   && 32'(long_level) <= LONG_DEPTH_DEF
                   && 32'(perm_level) <= PERM_DEPTH_DEF)
        else $error("fill count beyond table depth");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(short_level) && $stable(ok))
        else $error("stalled result word changed");

endmodule

bind timestamped_entry_aging_table_top teat_checker u_teat_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ok           (ok),
    .short_level  (short_level),
    .long_level   (long_level),
    .perm_level   (perm_level),
    .read_content (read_content),
    .read_year    (read_year)
);

`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for timestamped_entry_aging_table_top: adds, expires, reads, clears
// depends on teat_pkg and the block's rtl; holds its own model of the three tables
`timescale 1ns / 100ps

module tb_top;
    import teat_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [31:0] content;
        logic [31:0] related;
        stamp_t      stamp;
    } table_entry_t;

    typedef struct packed {
        logic        ok;
        logic [5:0]  short_cnt;
        logic [6:0]  long_cnt;
        logic [4:0]  perm_cnt;
        logic [31:0] rd_content;
        logic [31:0] rd_related;
        stamp_t      rd_stamp;
    } table_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [23:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [1:0]  mem_class;
    logic [13:0] stamp_year;
    logic [3:0]  stamp_month;
    logic [4:0]  stamp_day;
    logic [4:0]  stamp_hour;
    logic [5:0]  stamp_minute;
    logic [31:0] content_handle;
    logic [31:0] related_handle;
    logic [5:0]  entry_index;
    logic        out_valid;
    logic        out_stall;
    logic        ok;
    logic [5:0]  short_level;
    logic [6:0]  long_level;
    logic [4:0]  perm_level;
    logic [31:0] read_content;
    logic [31:0] read_related;
    logic [13:0] read_year;
    logic [3:0]  read_month;
    logic [4:0]  read_day;
    logic [4:0]  read_hour;
    logic [5:0]  read_minute;

    timestamped_entry_aging_table_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .mem_class(mem_class),
        .stamp_year(stamp_year), .stamp_month(stamp_month), .stamp_day(stamp_day),
        .stamp_hour(stamp_hour), .stamp_minute(stamp_minute),
        .content_handle(content_handle), .related_handle(related_handle),
        .entry_index(entry_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .ok(ok), .short_level(short_level), .long_level(long_level),
        .perm_level(perm_level), .read_content(read_content),
        .read_related(read_related), .read_year(read_year), .read_month(read_month),
        .read_day(read_day), .read_hour(read_hour), .read_minute(read_minute)
    );

    // model state: one row per class, short / long / permanent
    table_entry_t  tables [3][64];
    int unsigned   fills [3];
    int unsigned   depths [3] = '{SHORT_DEPTH_DEF, LONG_DEPTH_DEF, PERM_DEPTH_DEF};
    logic [23:0]   timeouts [2];

    table_result_t pending_results [$];
    int            errors;
    int            cycles;
    int            send_idle_pct;
    int            stall_pct;
    int            hold_cycles;
    int            base_year;
    int            base_month;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stall, or a long counted hold-off when requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic longint day_count(input stamp_t s);
        longint y, p, d, mlen;
        int     m;
        y = longint'(s.year);
        d = 0;
        if (y >= 1)
        begin
            p = y - 1;
            d = p * 365 + p / 4 - p / 100 + p / 400;
        end
        for (m = 1; m < int'(s.month); m++)
        begin
            case (m)
                1, 3, 5, 7, 8, 10, 12: mlen = 31;
                4, 6, 9, 11:           mlen = 30;
                2:                     mlen = ((y % 4 == 0) && ((y % 100 != 0)
                                              || (y % 400 == 0))) ? 29 : 28;
                default:               mlen = 0;
            endcase
            d += mlen;
        end
        return d + longint'(s.day) - 1;
    endfunction

    function automatic longint age_in_minutes(input stamp_t e, input stamp_t now);
        return (day_count(now) - day_count(e)) * 1440
             + (longint'(now.hour) * 60 + longint'(now.minute))
             - (longint'(e.hour) * 60 + longint'(e.minute));
    endfunction

    function automatic table_result_t predict_table_op(input opcode_t op,
            input mem_class_t cls, input stamp_t st, input logic [31:0] c,
            input logic [31:0] r, input logic [5:0] idx);
        table_result_t res;
        int unsigned   kept;
        int            t;
        res = '0;
        case (op)
            OP_ADD:
                if (cls != CLS_INVALID && fills[cls] < depths[cls])
                begin
                    tables[cls][fills[cls]] = '{content: c, related: r, stamp: st};
                    fills[cls]++;
                    res.ok = 1'b1;
                end
            OP_EXPIRE:
            begin
                for (t = 0; t < 2; t++)
                begin
                    kept = 0;
                    for (int unsigned i = 0; i < fills[t]; i++)
                    begin
                        if (age_in_minutes(tables[t][i].stamp, st) <= longint'(timeouts[t]))
                        begin
                            tables[t][kept] = tables[t][i];
                            kept++;
                        end
                    end
                    fills[t] = kept;
                end
                res.ok = 1'b1;
            end
            OP_READ:
                if (cls != CLS_INVALID && idx < fills[cls])
                begin
                    res.ok = 1'b1;
                    res.rd_content = tables[cls][idx].content;
                    res.rd_related = tables[cls][idx].related;
                    res.rd_stamp   = tables[cls][idx].stamp;
                end
            default:
            begin
                fills = '{0, 0, 0};
                res.ok = 1'b1;
            end
        endcase
        res.short_cnt = 6'(fills[0]);
        res.long_cnt  = 7'(fills[1]);
        res.perm_cnt  = 5'(fills[2]);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        table_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word: expected none, actual ok=%0b",
                         $time, ok);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("ok", 32'(e.ok), 32'(ok));
                check_field("short_level", 32'(e.short_cnt), 32'(short_level));
                check_field("long_level", 32'(e.long_cnt), 32'(long_level));
                check_field("perm_level", 32'(e.perm_cnt), 32'(perm_level));
                check_field("read_content", e.rd_content, read_content);
                check_field("read_related", e.rd_related, read_related);
                check_field("read_year", 32'(e.rd_stamp.year), 32'(read_year));
                check_field("read_month", 32'(e.rd_stamp.month), 32'(read_month));
                check_field("read_day", 32'(e.rd_stamp.day), 32'(read_day));
                check_field("read_hour", 32'(e.rd_stamp.hour), 32'(read_hour));
                check_field("read_minute", 32'(e.rd_stamp.minute), 32'(read_minute));
            end
        end
    end

    // one word: optional idle gap, present, wait for acceptance, predict
    task automatic send_word(input opcode_t op, input mem_class_t cls, input stamp_t st,
                             input logic [31:0] c, input logic [31:0] r,
                             input int idx);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        opcode         <= op;
        mem_class      <= cls;
        stamp_year     <= st.year;
        stamp_month    <= st.month;
        stamp_day      <= st.day;
        stamp_hour     <= st.hour;
        stamp_minute   <= st.minute;
        content_handle <= c;
        related_handle <= r;
        entry_index    <= 6'(idx);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(predict_table_op(op, cls, st, c, r, 6'(idx)));
    endtask

    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_timeout(input cfg_index_t which, input logic [23:0] value);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        timeouts[which] = value;
    endtask

    function automatic stamp_t mk_stamp(input int y, input int mo, input int d,
                                        input int h, input int mi);
        return '{year: 14'(y), month: 4'(mo), day: 5'(d), hour: 5'(h), minute: 6'(mi)};
    endfunction

    // timestamps clustered around the current base so ages straddle the timeouts
    function automatic stamp_t near_stamp();
        return mk_stamp(base_year, base_month + $urandom_range(0, 1),
                        ($urandom_range(0, 9) == 0) ? $urandom_range(29, 31)
                                                    : $urandom_range(1, 28),
                        $urandom_range(0, 23), $urandom_range(0, 59));
    endfunction

    task automatic send_random_item;
        int     pick;
        stamp_t st;
        pick = $urandom_range(0, 99);
        st = near_stamp();
        if (pick < 8)
            send_word(opcode_t'($urandom_range(0, 3)), mem_class_t'($urandom_range(0, 3)),
                      stamp_t'(34'({$urandom, $urandom})), $urandom, $urandom,
                      $urandom_range(0, 63));
        else if (pick < 55)
            send_word(OP_ADD, mem_class_t'($urandom_range(0, 2)), st, $urandom, $urandom, 0);
        else if (pick < 75)
            send_word(OP_READ, mem_class_t'($urandom_range(0, 2)), st, $urandom, $urandom,
                      $urandom_range(0, 40));
        else if (pick < 97)
            send_word(OP_EXPIRE, mem_class_t'($urandom_range(0, 3)), st, $urandom,
                      $urandom, $urandom_range(0, 63));
        else
            send_word(OP_CLEAR, mem_class_t'($urandom_range(0, 3)), st, $urandom,
                      $urandom, $urandom_range(0, 63));
    endtask

    task automatic test_directed;
        send_word(OP_ADD, CLS_SHORT, mk_stamp(1, 1, 1, 0, 0), 32'h0, 32'hffffffff, 0);
        send_word(OP_ADD, CLS_LONG, mk_stamp(9999, 12, 31, 23, 59), 32'hffffffff, 32'h0, 0);
        send_word(OP_ADD, CLS_PERM, mk_stamp(0, 0, 0, 31, 63), 32'ha5a5a5a5, 32'h5a5a5a5a, 0);
        send_word(OP_ADD, CLS_PERM, mk_stamp(16383, 15, 31, 24, 60), 32'h1, 32'h2, 0);
        send_word(OP_ADD, CLS_INVALID, mk_stamp(2000, 2, 29, 12, 0), 32'h3, 32'h4, 0);
        send_word(OP_READ, CLS_SHORT, mk_stamp(1, 1, 1, 0, 0), 0, 0, 0);
        send_word(OP_READ, CLS_LONG, mk_stamp(1, 1, 1, 0, 0), 0, 0, 0);
        send_word(OP_READ, CLS_PERM, mk_stamp(1, 1, 1, 0, 0), 0, 0, 1);
        send_word(OP_READ, CLS_PERM, mk_stamp(1, 1, 1, 0, 0), 0, 0, 2);
        send_word(OP_READ, CLS_INVALID, mk_stamp(1, 1, 1, 0, 0), 0, 0, 0);
        send_word(OP_READ, CLS_SHORT, mk_stamp(1, 1, 1, 0, 0), 0, 0, 63);
        // short entry exactly at the timeout survives, one minute older goes
        send_word(OP_ADD, CLS_SHORT, mk_stamp(2000, 2, 28, 16, 0), 32'h10, 32'h11, 0);
        send_word(OP_ADD, CLS_SHORT, mk_stamp(2000, 2, 28, 15, 59), 32'h12, 32'h13, 0);
        // long entry in the future never expires
        send_word(OP_ADD, CLS_LONG, mk_stamp(2100, 3, 1, 0, 0), 32'h20, 32'h21, 0);
        send_word(OP_EXPIRE, CLS_INVALID, mk_stamp(2000, 2, 29, 0, 0), 0, 0, 0);
        send_word(OP_READ, CLS_SHORT, mk_stamp(1, 1, 1, 0, 0), 0, 0, 0);
        send_word(OP_READ, CLS_LONG, mk_stamp(1, 1, 1, 0, 0), 0, 0, 0);
        send_word(OP_EXPIRE, CLS_PERM, mk_stamp(0, 0, 0, 0, 0), 0, 0, 0);
        send_word(OP_CLEAR, CLS_LONG, mk_stamp(1, 1, 1, 0, 0), 0, 0, 0);
        send_word(OP_READ, CLS_PERM, mk_stamp(1, 1, 1, 0, 0), 0, 0, 0);
        drain();
    endtask

    task automatic test_random(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        base_year     = $urandom_range(1, 9998);
        base_month    = $urandom_range(1, 11);
        repeat (n) send_random_item();
        drain();
    endtask

    task automatic test_backpressure;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 400;
        repeat (40) send_random_item();
        drain();
    endtask

    task automatic test_sender_pause;
        send_idle_pct = 27;
        stall_pct     = 27;
        repeat (30) send_random_item();
        drain();
        repeat (30) send_random_item();
        drain();
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        base_year = 2000;
        base_month = 1;
        fills = '{0, 0, 0};
        timeouts[0] = SHORT_TMO_RST;
        timeouts[1] = LONG_TMO_RST;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        opcode = '0;
        mem_class = '0;
        stamp_year = '0;
        stamp_month = '0;
        stamp_day = '0;
        stamp_hour = '0;
        stamp_minute = '0;
        content_handle = '0;
        related_handle = '0;
        entry_index = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(350, 0, 0);
        write_timeout(CFG_SHORT_TMO, 24'd0);
        write_timeout(CFG_LONG_TMO, 24'hffffff);
        test_random(350, 58, 0);
        write_timeout(CFG_SHORT_TMO, 24'hffffff);
        write_timeout(CFG_LONG_TMO, 24'd0);
        test_random(350, 0, 58);
        write_timeout(CFG_SHORT_TMO, 24'($urandom_range(60, 20000)));
        write_timeout(CFG_LONG_TMO, 24'($urandom_range(20000, 120000)));
        test_random(350, 27, 27);
        test_backpressure();
        test_sender_pause();

        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
